/* rtl/core/fpame_pkg.sv */
// Shared types, codes and constants of the fixed-point affine matrix engine.
`default_nettype none

package fpame_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int WORD_BITS_DEFAULT = 32;
   localparam int MUL_MAX_BITS      = 32;
   localparam int MATRIX_DIM        = 4;
   localparam int MATRIX_SIZE       = 16;

   // Multiplier passes per product: split the right-hand operand once words pass 32 bits.
   function automatic int mul_chunks(input int word_bits);
      return (word_bits > MUL_MAX_BITS) ? 2 : 1;
   endfunction

   typedef enum logic [1:0] {
      KIND_IDENTITY = 2'd0,
      KIND_LOAD     = 2'd1,
      KIND_POINT    = 2'd2,
      KIND_UNUSED   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      SQ_IDLE,
      SQ_RUN,
      SQ_DRAIN,
      SQ_TAKE,
      SQ_PUSH
   } state_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [3:0]        position;
      logic signed [31:0] value;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic signed [31:0] out_w;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic issue;
      logic bypass;
      logic chunk;
   } mac_ctl_type;

endpackage

`default_nettype wire

/* rtl/core/fpame_mac.sv */
// Shared multiply-accumulate unit with floor scaling and saturation.
`default_nettype none

module fpame_mac #(
   parameter int FRAC_BITS = fpame_pkg::FRAC_BITS_DEFAULT,
   parameter int WORD_BITS = fpame_pkg::WORD_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  fpame_pkg::mac_ctl_type      ctl,
   input  logic signed [WORD_BITS-1:0] a_word,
   input  logic signed [WORD_BITS-1:0] b_word,
   output logic signed [WORD_BITS-1:0] res_word,
   output logic                        res_sat
);
   import fpame_pkg::*;

   localparam int CHUNKS     = mul_chunks(WORD_BITS);
   localparam int CHUNK_BITS = (WORD_BITS + CHUNKS - 1) / CHUNKS;
   localparam int EXT_BITS   = CHUNKS * CHUNK_BITS;
   localparam int PROD_BITS  = WORD_BITS + CHUNK_BITS + 1;
   localparam int ACC_BITS   =
      ((2 * WORD_BITS > WORD_BITS + FRAC_BITS) ? 2 * WORD_BITS : WORD_BITS + FRAC_BITS) + 2;
   localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   logic signed [EXT_BITS-1:0]   b_ext;
   logic        [CHUNK_BITS-1:0] b_slice;
   logic                         top_chunk;
   logic signed [CHUNK_BITS:0]   b_part;
   logic signed [PROD_BITS-1:0]  prod;
   logic signed [ACC_BITS-1:0]   term_in;
   logic signed [ACC_BITS-1:0]   term_ff;
   logic                         term_valid_ff;
   logic signed [ACC_BITS-1:0]   acc_in;
   logic signed [ACC_BITS-1:0]   acc_ff;
   logic signed [ACC_BITS-1:0]   shifted;
   logic [ACC_BITS-WORD_BITS:0]  high_bits;
   logic                         fits;

   always_comb begin
      b_ext     = EXT_BITS'(b_word);
      b_slice   = b_ext[ctl.chunk*CHUNK_BITS +: CHUNK_BITS];
      top_chunk = (int'(ctl.chunk) == CHUNKS - 1);
      // only the top slice carries the sign; lower slices are unsigned
      b_part    = {top_chunk & b_slice[CHUNK_BITS-1], b_slice};
      prod      = a_word * b_part;
      if (ctl.bypass) begin
         term_in = ctl.chunk ? '0 : (ACC_BITS'(a_word) <<< FRAC_BITS);
      end else begin
         term_in = ACC_BITS'(prod) <<< (ctl.chunk * CHUNK_BITS);
      end
   end

   always_comb begin
      if (ctl.clear) begin
         acc_in = '0;
      end else if (term_valid_ff) begin
         acc_in = acc_ff + term_ff;
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_valid_ff <= 1'b0;
      end else begin
         term_valid_ff <= ctl.issue;
      end
   end

   always_ff @(posedge clock) begin
      term_ff <= term_in;
      acc_ff  <= acc_in;
   end

   // floor shift, then saturate when the bits above the word are not all sign
   always_comb begin
      shifted   = acc_ff >>> FRAC_BITS;
      high_bits = shifted[ACC_BITS-1:WORD_BITS-1];
      fits      = (&high_bits) | ~(|high_bits);
      res_sat   = ~fits;
      if (fits) begin
         res_word = shifted[WORD_BITS-1:0];
      end else begin
         res_word = acc_ff[ACC_BITS-1] ? WORD_MIN : WORD_MAX;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/fixed_point_affine_matrix_engine.sv */
// Top level of the fixed-point 4x4 affine matrix engine.
// Holds a column-major 4x4 transform matrix in signed fixed point (FRAC_BITS fraction
// bits in WORD_BITS-bit words). An identity item and a load item at positions 0 to 14
// are taken while idle and leave the block idle. A load at position 15 multiplies the
// matrix by the operand on one shared multiply-accumulate unit, element by element for
// all 16 elements, each product in one pass for WORD_BITS up to 32 and in two above. A
// transform item computes its four rows in turn, then waits to register its result
// while the previous result is still held. The block takes no item while a multiply
// or transform runs. Sums are exact, floored by FRAC_BITS and saturated; the sticky
// flag is cleared only by an identity item or a reset.
`default_nettype none

module fixed_point_affine_matrix_engine #(
   parameter int FRAC_BITS = fpame_pkg::FRAC_BITS_DEFAULT,
   parameter int WORD_BITS = fpame_pkg::WORD_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  fpame_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output fpame_pkg::rsp_type rsp_data
);
   import fpame_pkg::*;

   localparam int         CHUNKS     = mul_chunks(WORD_BITS);
   localparam logic       LAST_CHUNK = 1'(CHUNKS - 1);
   localparam logic [1:0] LAST_K     = 2'(MATRIX_DIM - 1);
   localparam logic [3:0] LAST_POS   = 4'(MATRIX_SIZE - 1);
   localparam logic [3:0] LAST_ROW   = 4'(MATRIX_DIM - 1);
   localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic signed [WORD_BITS-1:0] DIAG_ONE =
      (FRAC_BITS >= WORD_BITS - 1) ? WORD_MAX : WORD_BITS'(64'sd1 <<< FRAC_BITS);

   state_type                   state_ff, state_in;
   logic [3:0]                  elem_ff, elem_in;
   logic [1:0]                  k_ff, k_in;
   logic                        chunk_ff, chunk_in;
   logic                        mult_ff, mult_in;
   logic                        take;
   logic                        push;
   logic                        accept;
   mac_ctl_type                 mac_ctl;

   logic signed [WORD_BITS-1:0] mat_ff [MATRIX_SIZE];
   logic signed [WORD_BITS-1:0] op_ff  [MATRIX_SIZE];
   logic signed [WORD_BITS-1:0] tmp_ff [MATRIX_SIZE];
   logic signed [WORD_BITS-1:0] pt_ff  [MATRIX_DIM-1];
   logic                        sticky_ff;
   logic                        rsp_valid_ff;
   rsp_type                     rsp_ff;

   logic signed [WORD_BITS-1:0] a_word;
   logic signed [WORD_BITS-1:0] b_word;
   logic signed [WORD_BITS-1:0] res_word;
   logic                        res_sat;
   logic [3:0]                  last_elem;

   assign accept    = req_valid & req_ready;
   assign last_elem = mult_ff ? LAST_POS : LAST_ROW;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQ_IDLE;
         elem_ff  <= '0;
         k_ff     <= '0;
         chunk_ff <= 1'b0;
         mult_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         elem_ff  <= elem_in;
         k_ff     <= k_in;
         chunk_ff <= chunk_in;
         mult_ff  <= mult_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      elem_in        = elem_ff;
      k_in           = k_ff;
      chunk_in       = chunk_ff;
      mult_in        = mult_ff;
      req_ready      = 1'b0;
      take           = 1'b0;
      push           = 1'b0;
      mac_ctl        = '0;
      unique case (state_ff)
         SQ_IDLE: begin
            req_ready = 1'b1;
            elem_in   = '0;
            k_in      = '0;
            chunk_in  = 1'b0;
            if (req_valid) begin
               if (req_data.kind == KIND_LOAD && req_data.position == LAST_POS) begin
                  mult_in  = 1'b1;
                  state_in = SQ_RUN;
               end else if (req_data.kind == KIND_POINT) begin
                  mult_in  = 1'b0;
                  state_in = SQ_RUN;
               end
            end
         end
         SQ_RUN: begin
            mac_ctl.issue  = 1'b1;
            mac_ctl.clear  = (k_ff == '0) && !chunk_ff;
            // last step of a transform row adds the translation column
            mac_ctl.bypass = !mult_ff && (k_ff == LAST_K);
            mac_ctl.chunk  = chunk_ff;
            if (chunk_ff == LAST_CHUNK) begin
               chunk_in = 1'b0;
               if (k_ff == LAST_K) begin
                  k_in     = '0;
                  state_in = SQ_DRAIN;
               end else begin
                  k_in = k_ff + 2'd1;
               end
            end else begin
               chunk_in = ~chunk_ff;
            end
         end
         SQ_DRAIN: begin
            state_in = SQ_TAKE;
         end
         SQ_TAKE: begin
            take = 1'b1;
            if (elem_ff == last_elem) begin
               state_in = mult_ff ? SQ_IDLE : SQ_PUSH;
            end else begin
               elem_in  = elem_ff + 4'd1;
               state_in = SQ_RUN;
            end
         end
         SQ_PUSH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               push     = 1'b1;
               state_in = SQ_IDLE;
            end
         end
         default: begin
            state_in = SQ_IDLE;
         end
      endcase
   end

   // operand selection for the shared unit
   always_comb begin
      a_word = mat_ff[{k_ff, elem_ff[1:0]}];
      if (mult_ff) begin
         b_word = op_ff[{elem_ff[3:2], k_ff}];
      end else begin
         unique case (k_ff)
            2'd0:    b_word = pt_ff[0];
            2'd1:    b_word = pt_ff[1];
            2'd2:    b_word = pt_ff[2];
            default: b_word = '0;
         endcase
      end
   end

   fpame_mac #(
      .FRAC_BITS (FRAC_BITS),
      .WORD_BITS (WORD_BITS)
   ) u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctl      (mac_ctl),
      .a_word   (a_word),
      .b_word   (b_word),
      .res_word (res_word),
      .res_sat  (res_sat)
   );

   // transform matrix and sticky flag
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MATRIX_SIZE; i++) begin
            mat_ff[i] <= (4'(i) >> 2 == (4'(i) & 4'd3)) ? DIAG_ONE : '0;
         end
         sticky_ff <= 1'b0;
      end else begin
         if (accept && req_data.kind == KIND_IDENTITY) begin
            for (int i = 0; i < MATRIX_SIZE; i++) begin
               mat_ff[i] <= (4'(i) >> 2 == (4'(i) & 4'd3)) ? DIAG_ONE : '0;
            end
            sticky_ff <= 1'b0;
         end else if (take) begin
            sticky_ff <= sticky_ff | res_sat;
            // last product element: replace the whole matrix at once
            if (mult_ff && elem_ff == LAST_POS) begin
               for (int i = 0; i < MATRIX_SIZE - 1; i++) begin
                  mat_ff[i] <= tmp_ff[i];
               end
               mat_ff[MATRIX_SIZE-1] <= res_word;
            end
         end
      end
   end

   // operand, point and temporary stores
   always_ff @(posedge clock) begin
      if (accept && req_data.kind == KIND_LOAD) begin
         op_ff[req_data.position] <= WORD_BITS'(req_data.value);
      end
      if (accept && req_data.kind == KIND_POINT) begin
         pt_ff[0] <= WORD_BITS'(req_data.x);
         pt_ff[1] <= WORD_BITS'(req_data.y);
         pt_ff[2] <= WORD_BITS'(req_data.z);
      end
      if (take) begin
         tmp_ff[elem_ff] <= res_word;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_ff.out_x     <= 32'(tmp_ff[0]);
         rsp_ff.out_y     <= 32'(tmp_ff[1]);
         rsp_ff.out_z     <= 32'(tmp_ff[2]);
         rsp_ff.out_w     <= 32'(tmp_ff[3]);
         rsp_ff.saturated <= sticky_ff;
      end
   end

endmodule

`default_nettype wire
